// ----- rtl/bbcd_pkg.sv -----
// Package for the buffer cache directory: sizes, codes and the entry type.
// Used by block_buffer_cache_directory; no dependencies.
package bbcd_pkg;
    localparam int Buffers    = 32;
    localparam int IdxW       = $clog2(Buffers);
    localparam int ScanW      = $clog2(2 * Buffers) + 1;
    localparam logic [7:0] CountMax = 8'd255;
    localparam logic [31:0] FsReset = 32'd2000;

    localparam logic [1:0] OpRead    = 2'd0;
    localparam logic [1:0] OpRelease = 2'd1;
    localparam logic [1:0] OpPin     = 2'd2;
    localparam logic [1:0] OpUnpin   = 2'd3;

    localparam logic [1:0] StOk        = 2'd0;
    localparam logic [1:0] StNoFree    = 2'd1;
    localparam logic [1:0] StUnderflow = 2'd2;

    typedef struct packed {
        logic [31:0] dev;
        logic [31:0] blk;
        logic [7:0]  cnt;
        logic        sc;
        logic        cv;
    } t_entry;

    localparam int EntryW = $bits(t_entry);
endpackage

// ----- rtl/block_buffer_cache_directory.sv -----
// Buffer cache directory, one item at a time. A read sweeps all 32 entry tags and, on a miss,
// runs a clock scan of up to 64 steps; a read-ahead adds a second tag sweep and scan. All
// entry accesses go through the one entry RAM.
// Reset clears all entries through a clearing pass during which no item is taken.
// Results sit in an output register; the next item is taken once the last beat leaves.
module block_buffer_cache_directory (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_device,
    input  logic [31:0] i_block_number,
    input  logic [4:0]  i_held_buffer,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [4:0]  o_result_buffer,
    output logic        o_hit,
    output logic        o_fill_needed,
    output logic        o_is_readahead,
    output logic [1:0]  o_status,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);
    localparam int IW = bbcd_pkg::IdxW;
    localparam int SW = bbcd_pkg::ScanW;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LREQ  = 4'd2;  // tag sweep, one entry a cycle
    localparam logic [3:0] S_LEND  = 4'd3;  // last lookup data returns
    localparam logic [3:0] S_SCAN  = 4'd4;  // clock scan step
    localparam logic [3:0] S_HRD   = 4'd5;  // read held/hit entry
    localparam logic [3:0] S_HMOD  = 4'd6;  // modify held/hit entry
    localparam logic [3:0] S_OUT   = 4'd7;  // results pending

    logic [3:0]        r_state;
    logic [31:0]       r_fs;
    logic [1:0]        r_op;
    logic [31:0]       r_dev, r_blk, r_key;
    logic [4:0]        r_held;
    logic              r_ra;          // current pass is read-ahead
    logic [IW:0]       r_ptr;         // sweep address counter
    logic              r_rvld;
    logic [IW-1:0]     r_raddr_q;
    logic              r_found;
    logic [IW-1:0]     r_fidx;
    logic [IW-1:0]     r_hand;
    logic [SW-1:0]     r_scnt;
    logic              r_swait;       // scan read in flight
    logic [31:0]       r_pdev, r_pblk;
    logic              r_pknown;
    logic              r_seq;
    // first result
    logic [4:0]        r_b0;
    logic              r_hit0, r_fill0;
    logic [1:0]        r_st0;
    logic              r_two, r_beat;
    logic [4:0]        r_b1;

    logic              we;
    logic [IW-1:0]     waddr, raddr;
    bbcd_pkg::t_entry  wdata, rdata;

    bbcd_ram #(.Depth(bbcd_pkg::Buffers), .Width(bbcd_pkg::EntryW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic accept;
    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    logic out_take;
    assign out_take = o_valid && !i_stall;
    logic match;
    assign match = r_rvld && rdata.dev == r_dev && rdata.blk == r_key;

    // Memory port drive
    always_comb begin
        we = 1'b0;
        waddr = r_hand;
        wdata = rdata;
        raddr = r_ptr[IW-1:0];
        unique case (r_state)
            S_CLR: begin
                we = 1'b1;
                waddr = r_ptr[IW-1:0];
                wdata = '0;
            end
            S_SCAN: begin
                raddr = r_hand;
                if (r_swait && rdata.cnt == 8'd0) begin
                    we = 1'b1;
                    if (rdata.sc) begin
                        wdata.sc = 1'b0;
                    end else begin
                        wdata.dev = r_dev;
                        wdata.blk = r_key;
                        wdata.cv  = 1'b1;
                        wdata.sc  = !r_ra;
                        wdata.cnt = r_ra ? 8'd0 : 8'd1;
                    end
                end
            end
            S_HRD: raddr = r_fidx;
            S_HMOD: begin
                waddr = r_fidx;
                raddr = r_fidx;
                if (r_beat) begin
                    // read-ahead decision only, entry already written
                    we = 1'b0;
                end else if (r_op == bbcd_pkg::OpRead) begin
                    we = 1'b1;
                    wdata.sc = 1'b1;
                    wdata.cv = 1'b1;
                    if (rdata.cnt != bbcd_pkg::CountMax) wdata.cnt = rdata.cnt + 8'd1;
                end else if (r_op == bbcd_pkg::OpPin) begin
                    we = 1'b1;
                    if (rdata.cnt != bbcd_pkg::CountMax) wdata.cnt = rdata.cnt + 8'd1;
                end else begin
                    we = (rdata.cnt != 8'd0);
                    wdata.cnt = rdata.cnt - 8'd1;
                end
            end
            default: ;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_ptr    <= '0;
            r_fs     <= bbcd_pkg::FsReset;
            r_hand   <= '0;
            r_pknown <= 1'b0;
            r_pdev   <= '0;
            r_pblk   <= '0;
            r_rvld   <= 1'b0;
            r_swait  <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) r_fs <= i_cfg_data;
            r_rvld <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == (IW+1)'(bbcd_pkg::Buffers - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (accept) begin
                    r_op   <= i_operation;
                    r_dev  <= i_device;
                    r_blk  <= i_block_number;
                    r_key  <= i_block_number;
                    r_held <= i_held_buffer;
                    r_ra   <= 1'b0;
                    r_two  <= 1'b0;
                    r_beat <= 1'b0;
                    r_found <= 1'b0;
                    r_fill0 <= 1'b0;
                    r_ptr  <= '0;
                    r_fidx <= i_held_buffer[IW-1:0];
                    if (i_operation == bbcd_pkg::OpRead) begin
                        r_state <= S_LREQ;
                    end else if (32'(i_held_buffer) >= 32'(bbcd_pkg::Buffers)) begin
                        r_b0 <= i_held_buffer; r_hit0 <= 1'b0; r_fill0 <= 1'b0;
                        r_st0 <= bbcd_pkg::StOk;
                        r_state <= S_OUT;
                        o_valid <= 1'b1;
                    end else begin
                        r_state <= S_HRD;
                    end
                end
                S_LREQ, S_LEND: begin
                    if (match) begin
                        r_found <= 1'b1;
                        r_fidx  <= r_raddr_q;
                    end
                    if (r_state == S_LREQ) begin
                        r_rvld <= 1'b1;
                        r_raddr_q <= r_ptr[IW-1:0];
                        r_ptr <= r_ptr + 1'b1;
                        if (r_ptr == (IW+1)'(bbcd_pkg::Buffers - 1)) r_state <= S_LEND;
                    end else begin
                        r_scnt  <= '0;
                        r_swait <= 1'b0;
                        if (r_ra) begin
                            if (match || r_found) begin
                                r_state <= S_OUT; o_valid <= 1'b1;
                            end else r_state <= S_SCAN;
                        end else if (match || r_found) begin
                            r_state <= S_HRD;
                        end else r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_swait <= !r_swait;
                    if (r_swait) begin
                        r_hand <= (r_hand == IW'(bbcd_pkg::Buffers - 1)) ? '0 : r_hand + 1'b1;
                        r_scnt <= r_scnt + 1'b1;
                        if (rdata.cnt == 8'd0 && !rdata.sc) begin
                            if (r_ra) begin
                                r_two <= 1'b1; r_b1 <= 5'(r_hand);
                                r_state <= S_OUT; o_valid <= 1'b1;
                            end else begin
                                r_b0 <= 5'(r_hand); r_hit0 <= 1'b0; r_fill0 <= 1'b1;
                                r_st0 <= bbcd_pkg::StOk;
                                r_state <= S_HRD;
                                r_op <= bbcd_pkg::OpRelease; // marks post-read step
                            end
                        end else if (r_scnt == SW'(2 * bbcd_pkg::Buffers - 1)) begin
                            if (!r_ra) begin
                                r_b0 <= '0; r_hit0 <= 1'b0; r_fill0 <= 1'b0;
                                r_st0 <= bbcd_pkg::StNoFree;
                            end
                            r_state <= S_OUT; o_valid <= 1'b1;
                        end
                    end
                end
                S_HRD: begin
                    if (r_op == bbcd_pkg::OpRelease && r_st0 == bbcd_pkg::StOk
                        && r_fill0 && !r_hit0 && r_blk == r_key && r_beat == 1'b0
                        && r_found == 1'b0) begin
                        // miss victim written: update sequence tracking
                        r_seq    <= r_pknown && r_pdev == r_dev && r_pblk + 32'd1 == r_blk;
                        r_pdev   <= r_dev; r_pblk <= r_blk; r_pknown <= 1'b1;
                        r_beat   <= 1'b1;
                        r_state  <= S_HMOD;
                    end else begin
                        r_state <= S_HMOD;
                    end
                end
                S_HMOD: begin
                    if (r_beat) begin
                        // post-miss: decide read-ahead
                        r_beat <= 1'b0;
                        if (r_seq && r_blk + 32'd1 < r_fs) begin
                            r_ra <= 1'b1; r_key <= r_blk + 32'd1;
                            r_found <= 1'b0; r_ptr <= '0; r_state <= S_LREQ;
                        end else begin
                            r_state <= S_OUT; o_valid <= 1'b1;
                        end
                    end else if (r_op == bbcd_pkg::OpRead) begin
                        r_b0 <= 5'(r_fidx); r_hit0 <= 1'b1; r_fill0 <= !rdata.cv;
                        r_st0 <= bbcd_pkg::StOk;
                        r_seq <= r_pknown && r_pdev == r_dev && r_pblk + 32'd1 == r_blk;
                        r_pdev <= r_dev; r_pblk <= r_blk; r_pknown <= 1'b1;
                        r_beat <= 1'b1;
                        r_state <= S_HMOD;
                        r_op <= bbcd_pkg::OpPin; // no further entry write
                    end else begin
                        r_b0 <= r_held; r_hit0 <= 1'b0; r_fill0 <= 1'b0;
                        r_st0 <= (r_op != bbcd_pkg::OpPin && rdata.cnt == 8'd0)
                                 ? bbcd_pkg::StUnderflow : bbcd_pkg::StOk;
                        r_state <= S_OUT; o_valid <= 1'b1;
                    end
                end
                S_OUT: if (out_take) begin
                    if (r_two) begin
                        r_two <= 1'b0; r_b0 <= r_b1; r_hit0 <= 1'b0; r_fill0 <= 1'b1;
                        r_ra <= 1'b1; r_beat <= 1'b1;
                    end else begin
                        o_valid <= 1'b0; r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output beat fields
    assign o_result_buffer = r_b0;
    assign o_hit           = r_hit0 && !(r_beat && r_ra);
    assign o_fill_needed   = r_fill0;
    assign o_is_readahead  = r_beat && r_ra && r_state == S_OUT;
    assign o_status        = r_st0;
    assign o_last          = !r_two;

`ifndef NO_ASSERTIONS
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("output pending while idle");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_scnt < SW'(2 * bbcd_pkg::Buffers))
        else $error("clock scan overrun");
    a_no_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !we) else $error("entry write while idle");
`endif
endmodule

// ----- rtl/bbcd_ram.sv -----
// Single-port-write, single-read synchronous RAM holding directory entries.
// The entry width comes from the Width parameter; no package dependency.
module bbcd_ram #(
    parameter int Depth = 32,
    parameter int Width = 74
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // Write one entry, read one entry through a registered output
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
